/* rtl/core/rcm_pkg.sv */
// Shared types, widths and constants for the RAID-Z column mapper.
package rcm_pkg;

   localparam int OFFSET_W     = 60;
   localparam int SIZE_W       = 25;
   localparam int DEV_OFFSET_W = 61;
   localparam int COL_W        = 4;
   localparam int SHIFT_W      = 5;
   localparam int TCOL_W       = 5;
   localparam int PAR_W        = 2;
   localparam int LABEL_W      = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int REM_W        = 4;
   localparam int MAX_COLUMNS  = 16;
   localparam int SWAP_BIT     = 20;
   localparam int DIV_STEPS    = OFFSET_W;
   localparam int CNT_W        = $clog2(DIV_STEPS);
   localparam int SZ_FULL_W    = SIZE_W + 1 + (1 << SHIFT_W) - 1;

   localparam logic [SHIFT_W-1:0] SECTOR_SHIFT_RESET   = SHIFT_W'(12);
   localparam logic [TCOL_W-1:0]  TOTAL_COLUMNS_RESET  = TCOL_W'(4);
   localparam logic [PAR_W-1:0]   PARITY_COLUMNS_RESET = PAR_W'(1);
   localparam logic [LABEL_W-1:0] LABEL_OFFSET_RESET   = LABEL_W'(4194304);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SECTOR_SHIFT   = 2'd0,
      CSR_TOTAL_COLUMNS  = 2'd1,
      CSR_PARITY_COLUMNS = 2'd2,
      CSR_LABEL_OFFSET   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PREP1,
      ST_PREP2,
      ST_PREP3,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] sh;
      logic [TCOL_W-1:0]  tcols;
      logic [PAR_W-1:0]   np;
      logic [LABEL_W-1:0] label;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic step1;
      logic step2;
      logic prep1;
      logic prep2;
      logic prep3;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic geom_ok;
      logic none;
      logic last;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/raidz_column_map.sv */
// Top level of the RAID-Z column mapper: register file, sequencer and datapath.
// A request word is taken only in idle; the sequencer then runs the 60-step
// bit-serial division of the sector number, three prepare states, and emits one
// word per data column, stalling on a full output word; bad geometry is dropped.
// Reset (synchronous, active high): registers return to their defaults,
// the output word register empties and the sequencer returns to idle.
module raidz_column_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rcm_pkg::OFFSET_W-1:0]        req_block_offset,
   input  logic [rcm_pkg::SIZE_W-1:0]          req_block_size,
   input  logic [rcm_pkg::SIZE_W-1:0]          req_actual_bytes,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rcm_pkg::COL_W-1:0]           rsp_column_number,
   output logic [rcm_pkg::COL_W-1:0]           rsp_device_index,
   output logic [rcm_pkg::DEV_OFFSET_W-1:0]    rsp_device_byte_offset,
   output logic [rcm_pkg::SIZE_W-1:0]          rsp_column_bytes,
   output logic                                rsp_last_column,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rcm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rcm_pkg::LABEL_W-1:0]         csr_data
);

   rcm_pkg::cfg_type     cfg_ff, cfg_in;
   rcm_pkg::cmd_type     cmd;
   rcm_pkg::status_type  status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (rcm_pkg::csr_index_type'(csr_index))
            rcm_pkg::CSR_SECTOR_SHIFT:   cfg_in.sh    = csr_data[rcm_pkg::SHIFT_W-1:0];
            rcm_pkg::CSR_TOTAL_COLUMNS:  cfg_in.tcols = csr_data[rcm_pkg::TCOL_W-1:0];
            rcm_pkg::CSR_PARITY_COLUMNS: cfg_in.np    = csr_data[rcm_pkg::PAR_W-1:0];
            rcm_pkg::CSR_LABEL_OFFSET:   cfg_in.label = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sh    <= rcm_pkg::SECTOR_SHIFT_RESET;
         cfg_ff.tcols <= rcm_pkg::TOTAL_COLUMNS_RESET;
         cfg_ff.np    <= rcm_pkg::PARITY_COLUMNS_RESET;
         cfg_ff.label <= rcm_pkg::LABEL_OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcm_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .cmd                    (cmd),
      .status                 (status),
      .req_block_offset       (req_block_offset),
      .req_block_size         (req_block_size),
      .req_actual_bytes       (req_actual_bytes),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_column_number      (rsp_column_number),
      .rsp_device_index       (rsp_device_index),
      .rsp_device_byte_offset (rsp_device_byte_offset),
      .rsp_column_bytes       (rsp_column_bytes),
      .rsp_last_column        (rsp_last_column)
   );

endmodule

/* rtl/core/rcm_ctrl.sv */
// Sequencer for the column mapper: divide, prepare, then emit one column per word.
module rcm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rcm_pkg::status_type   status,
   output rcm_pkg::cmd_type      cmd
);

   rcm_pkg::state_type           state_ff, state_in;
   logic [rcm_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rcm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.geom_ok) begin
                  state_in = rcm_pkg::ST_DIVIDE;
               end
            end
         end
         rcm_pkg::ST_DIVIDE: begin
            cmd.step1 = 1'b1;
            cmd.step2 = (cnt_ff < rcm_pkg::CNT_W'(rcm_pkg::SIZE_W));
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == rcm_pkg::CNT_W'(rcm_pkg::DIV_STEPS - 1)) begin
               state_in = rcm_pkg::ST_PREP1;
            end
         end
         rcm_pkg::ST_PREP1: begin
            cmd.prep1 = 1'b1;
            state_in  = rcm_pkg::ST_PREP2;
         end
         rcm_pkg::ST_PREP2: begin
            cmd.prep2 = 1'b1;
            state_in  = rcm_pkg::ST_PREP3;
         end
         rcm_pkg::ST_PREP3: begin
            cmd.prep3 = 1'b1;
            state_in  = status.none ? rcm_pkg::ST_IDLE : rcm_pkg::ST_EMIT;
         end
         rcm_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last) begin
                  state_in = rcm_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = rcm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/rcm_datapath.sv */
// Datapath: serial dividers, column geometry, offsets and the output word register.
module rcm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  rcm_pkg::cfg_type                  cfg,
   input  rcm_pkg::cmd_type                  cmd,
   output rcm_pkg::status_type               status,
   input  logic [rcm_pkg::OFFSET_W-1:0]      req_block_offset,
   input  logic [rcm_pkg::SIZE_W-1:0]        req_block_size,
   input  logic [rcm_pkg::SIZE_W-1:0]        req_actual_bytes,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rcm_pkg::COL_W-1:0]         rsp_column_number,
   output logic [rcm_pkg::COL_W-1:0]         rsp_device_index,
   output logic [rcm_pkg::DEV_OFFSET_W-1:0]  rsp_device_byte_offset,
   output logic [rcm_pkg::SIZE_W-1:0]        rsp_column_bytes,
   output logic                              rsp_last_column
);

   localparam int OW = rcm_pkg::OFFSET_W;
   localparam int SW = rcm_pkg::SIZE_W;
   localparam int DW = rcm_pkg::DEV_OFFSET_W;
   localparam int TW = rcm_pkg::TCOL_W;
   localparam int RW = rcm_pkg::REM_W;
   localparam int FW = rcm_pkg::SZ_FULL_W;

   function automatic logic [SW-1:0] sat_size(input logic [FW-1:0] v);
      logic [SW-1:0] r;
      r = (|v[FW-1:SW]) ? {SW{1'b1}} : v[SW-1:0];
      return r;
   endfunction

   // working registers
   logic [OW-1:0] dvd1_ff, dvd1_in;
   logic [RW-1:0] rem1_ff, rem1_in;
   logic [SW-1:0] dvd2_ff, dvd2_in;
   logic [RW-1:0] rem2_ff, rem2_in;
   logic [SW-1:0] actual_ff, actual_in;
   logic          swap_ff, swap_in;
   logic [TW-1:0] bc_ff, bc_in;
   logic [TW-1:0] acols_ff, acols_in;
   logic [TW-1:0] cur_ff, cur_in;
   logic [DW-1:0] o_ff, o_in;
   logic [DW-1:0] step_ff, step_in;
   logic [DW-1:0] offa_ff, offa_in;
   logic [DW-1:0] offb_ff, offb_in;
   logic [SW-1:0] szhi_ff, szhi_in;
   logic [SW-1:0] szlo_ff, szlo_in;

   // output word
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rcm_pkg::COL_W-1:0]    colnum_ff, colnum_in;
   logic [rcm_pkg::COL_W-1:0]    dev_ff, dev_in;
   logic [DW-1:0]                doff_ff, doff_in;
   logic [SW-1:0]                bytes_ff, bytes_in;
   logic                         last_ff, last_in;

   // combinational helpers
   logic [TW-1:0] d1, d2;
   logic [TW-1:0] t1, t2, t1_sub, t2_sub;
   logic          ge1, ge2;
   logic [TW-1:0] np_ext;
   logic [TW-1:0] eidx, colsum, colv;
   logic          wrap;
   logic [SW-1:0] size_sel, take;
   logic          is_last;
   logic [FW-1:0] hi_full, lo_full;

   assign np_ext = TW'(cfg.np);
   assign d1     = cfg.tcols;
   assign d2     = cfg.tcols - np_ext;

   assign t1     = {rem1_ff, dvd1_ff[OW-1]};
   assign t1_sub = t1 - d1;
   assign ge1    = (t1 >= d1);
   assign t2     = {rem2_ff, dvd2_ff[SW-1]};
   assign t2_sub = t2 - d2;
   assign ge2    = (t2 >= d2);

   assign hi_full = FW'({1'b0, dvd2_ff} + (SW+1)'(1)) << cfg.sh;
   assign lo_full = FW'(dvd2_ff) << cfg.sh;

   assign eidx     = (swap_ff && cur_ff == TW'(1)) ? '0 : cur_ff;
   assign colsum   = TW'(rem1_ff) + eidx;
   assign wrap     = (colsum >= cfg.tcols);
   assign colv     = wrap ? (colsum - cfg.tcols) : colsum;
   assign size_sel = (cur_ff < bc_ff) ? szhi_ff : szlo_ff;
   assign take     = (actual_ff < size_sel) ? actual_ff : size_sel;
   assign is_last  = ((cur_ff + 1'b1) == acols_ff);

   assign status.geom_ok  = (cfg.tcols >= TW'(2)) &&
                            (cfg.tcols <= TW'(rcm_pkg::MAX_COLUMNS)) &&
                            (cfg.np != '0) && (np_ext < cfg.tcols);
   assign status.none     = (acols_ff <= np_ext);
   assign status.last     = is_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dvd1_in   = dvd1_ff;
      rem1_in   = rem1_ff;
      dvd2_in   = dvd2_ff;
      rem2_in   = rem2_ff;
      actual_in = actual_ff;
      swap_in   = swap_ff;
      bc_in     = bc_ff;
      acols_in  = acols_ff;
      cur_in    = cur_ff;
      o_in      = o_ff;
      step_in   = step_ff;
      offa_in   = offa_ff;
      offb_in   = offb_ff;
      szhi_in   = szhi_ff;
      szlo_in   = szlo_ff;
      colnum_in = colnum_ff;
      dev_in    = dev_ff;
      doff_in   = doff_ff;
      bytes_in  = bytes_ff;
      last_in   = last_ff;

      if (cmd.load) begin
         dvd1_in   = req_block_offset >> cfg.sh;
         dvd2_in   = req_block_size >> cfg.sh;
         rem1_in   = '0;
         rem2_in   = '0;
         actual_in = req_actual_bytes;
         swap_in   = (cfg.np == rcm_pkg::PAR_W'(1)) && req_block_offset[rcm_pkg::SWAP_BIT];
      end

      // restoring division, one quotient bit per step
      if (cmd.step1) begin
         rem1_in = ge1 ? t1_sub[RW-1:0] : t1[RW-1:0];
         dvd1_in = {dvd1_ff[OW-2:0], ge1};
      end
      if (cmd.step2) begin
         rem2_in = ge2 ? t2_sub[RW-1:0] : t2[RW-1:0];
         dvd2_in = {dvd2_ff[SW-2:0], ge2};
      end

      if (cmd.prep1) begin
         bc_in    = (rem2_ff == '0) ? '0 : (TW'(rem2_ff) + np_ext);
         acols_in = (dvd2_ff == '0) ? ((rem2_ff == '0) ? '0 : (TW'(rem2_ff) + np_ext))
                                    : cfg.tcols;
         o_in     = DW'(dvd1_ff) << cfg.sh;
         step_in  = DW'(1) << cfg.sh;
         szhi_in  = sat_size(hi_full);
         szlo_in  = sat_size(lo_full);
         cur_in   = np_ext;
      end
      if (cmd.prep2) begin
         offa_in = o_ff + DW'(cfg.label);
      end
      if (cmd.prep3) begin
         offb_in = offa_ff + step_ff;
      end

      if (cmd.emit) begin
         colnum_in = cur_ff[rcm_pkg::COL_W-1:0];
         dev_in    = colv[rcm_pkg::COL_W-1:0];
         doff_in   = wrap ? offb_ff : offa_ff;
         bytes_in  = take;
         last_in   = is_last;
         actual_in = actual_ff - take;
         cur_in    = cur_ff + 1'b1;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd1_ff   <= dvd1_in;
      rem1_ff   <= rem1_in;
      dvd2_ff   <= dvd2_in;
      rem2_ff   <= rem2_in;
      actual_ff <= actual_in;
      swap_ff   <= swap_in;
      bc_ff     <= bc_in;
      acols_ff  <= acols_in;
      cur_ff    <= cur_in;
      o_ff      <= o_in;
      step_ff   <= step_in;
      offa_ff   <= offa_in;
      offb_ff   <= offb_in;
      szhi_ff   <= szhi_in;
      szlo_ff   <= szlo_in;
      colnum_ff <= colnum_in;
      dev_ff    <= dev_in;
      doff_ff   <= doff_in;
      bytes_ff  <= bytes_in;
      last_ff   <= last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_column_number      = colnum_ff;
   assign rsp_device_index       = dev_ff;
   assign rsp_device_byte_offset = doff_ff;
   assign rsp_column_bytes       = bytes_ff;
   assign rsp_last_column        = last_ff;

   // a new word never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("column word emitted over a pending word");

   // remaining real bytes only shrink while columns go out
   a_actual_mono: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (actual_ff <= $past(actual_ff)))
      else $error("remaining bytes grew during emit");

   // the final column carries the last flag into the output word
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && is_last) |=> (rsp_valid_ff && rsp_last_column))
      else $error("last column word lost its flag");

endmodule

/* sim/raidz_column_map_checker.sv */
// Scoreboard for raidz_column_map: predicts column words per request and checks the rsp channel.
module raidz_column_map_checker
   import rcm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [OFFSET_W-1:0]     req_block_offset,
   input  logic [SIZE_W-1:0]       req_block_size,
   input  logic [SIZE_W-1:0]       req_actual_bytes,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [COL_W-1:0]        rsp_column_number,
   input  logic [COL_W-1:0]        rsp_device_index,
   input  logic [DEV_OFFSET_W-1:0] rsp_device_byte_offset,
   input  logic [SIZE_W-1:0]       rsp_column_bytes,
   input  logic                    rsp_last_column,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [LABEL_W-1:0]      csr_data,
   output int                      fail_count,
   output int                      words_pending
);

   typedef struct {
      logic [COL_W-1:0]        column_number;
      logic [COL_W-1:0]        device_index;
      logic [DEV_OFFSET_W-1:0] device_byte_offset;
      logic [SIZE_W-1:0]       column_bytes;
      logic                    last_column;
   } column_word_type;

   column_word_type    column_queue[$];
   logic [SHIFT_W-1:0] sector_shift;
   logic [TCOL_W-1:0]  total_columns;
   logic [PAR_W-1:0]   parity_columns;
   logic [LABEL_W-1:0] label_offset;
   int                 mismatches = 0;

   initial begin
      fail_count    = 0;
      words_pending = 0;
   end

   task automatic map_request(input logic [OFFSET_W-1:0] offset,
                              input logic [SIZE_W-1:0]   bsize,
                              input logic [SIZE_W-1:0]   actual);
      logic [63:0]     sector, sectors, first_col, base, quot, rem_s;
      logic [63:0]     big_cols, access_cols, data_cols, col, left, take, tmp;
      logic [63:0]     dev[MAX_COLUMNS];
      logic [63:0]     coff[MAX_COLUMNS];
      logic [63:0]     csize[MAX_COLUMNS];
      column_word_type w;
      int              c;
      if (total_columns >= 2 && total_columns <= MAX_COLUMNS && parity_columns != 0 &&
          parity_columns < total_columns) begin
         sector      = 64'(offset) >> sector_shift;
         sectors     = 64'(bsize) >> sector_shift;
         data_cols   = 64'(total_columns) - 64'(parity_columns);
         first_col   = sector % 64'(total_columns);
         base        = (sector / 64'(total_columns)) << sector_shift;
         quot        = sectors / data_cols;
         rem_s       = sectors - quot * data_cols;
         big_cols    = (rem_s == 0) ? 64'd0 : rem_s + 64'(parity_columns);
         access_cols = (quot == 0) ? big_cols : 64'(total_columns);
         if (access_cols > 64'(total_columns)) begin
            access_cols = 64'(total_columns);
         end
         for (c = 0; c < access_cols; c++) begin
            col     = first_col + 64'(c);
            coff[c] = base;
            if (col >= 64'(total_columns)) begin
               col     = col - 64'(total_columns);
               coff[c] = coff[c] + (64'd1 << sector_shift);
            end
            dev[c]   = col;
            csize[c] = (c < big_cols) ? (quot + 64'd1) << sector_shift : quot << sector_shift;
         end
         // single parity: the first two columns trade places on alternate megabytes
         if (parity_columns == 1 && offset[SWAP_BIT] && access_cols >= 2) begin
            tmp = dev[0];  dev[0]  = dev[1];  dev[1]  = tmp;
            tmp = coff[0]; coff[0] = coff[1]; coff[1] = tmp;
         end
         left = 64'(actual);
         for (c = int'(parity_columns); c < access_cols; c++) begin
            take                 = (left < csize[c]) ? left : csize[c];
            w.column_number      = COL_W'(c);
            w.device_index       = COL_W'(dev[c]);
            w.device_byte_offset = DEV_OFFSET_W'(coff[c] + 64'(label_offset));
            w.column_bytes       = SIZE_W'(take);
            w.last_column        = (64'(c) + 64'd1 == access_cols);
            left                 = left - take;
            column_queue.push_back(w);
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] expected,
                                input logic [63:0] actual);
      if (expected !== actual) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      end
   endtask

   task automatic check_word;
      column_word_type w;
      if (column_queue.size() == 0) begin
         mismatches++;
         $display("%0t: column word with none expected, actual col %0d dev %0d off %0h bytes %0h last %0b",
                  $time, rsp_column_number, rsp_device_index, rsp_device_byte_offset,
                  rsp_column_bytes, rsp_last_column);
      end else begin
         w = column_queue.pop_front();
         compare_field("column_number", 64'(w.column_number), 64'(rsp_column_number));
         compare_field("device_index", 64'(w.device_index), 64'(rsp_device_index));
         compare_field("device_byte_offset", 64'(w.device_byte_offset),
                       64'(rsp_device_byte_offset));
         compare_field("column_bytes", 64'(w.column_bytes), 64'(rsp_column_bytes));
         compare_field("last_column", 64'(w.last_column), 64'(rsp_last_column));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sector_shift   = SECTOR_SHIFT_RESET;
         total_columns  = TOTAL_COLUMNS_RESET;
         parity_columns = PARITY_COLUMNS_RESET;
         label_offset   = LABEL_OFFSET_RESET;
         column_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SECTOR_SHIFT:   sector_shift   = csr_data[SHIFT_W-1:0];
               CSR_TOTAL_COLUMNS:  total_columns  = csr_data[TCOL_W-1:0];
               CSR_PARITY_COLUMNS: parity_columns = csr_data[PAR_W-1:0];
               CSR_LABEL_OFFSET:   label_offset   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            map_request(req_block_offset, req_block_size, req_actual_bytes);
         end
         if (rsp_valid && rsp_ready) begin
            check_word();
         end
      end
      fail_count    <= mismatches;
      words_pending <= column_queue.size();
   end

endmodule

/* sim/raidz_column_map_tb.sv */
// Testbench top for raidz_column_map: stimulus, flow control and verdict.
module raidz_column_map_tb;
   import rcm_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OFFSET_W-1:0]     req_block_offset = '0;
   logic [SIZE_W-1:0]       req_block_size = '0;
   logic [SIZE_W-1:0]       req_actual_bytes = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [COL_W-1:0]        rsp_column_number;
   logic [COL_W-1:0]        rsp_device_index;
   logic [DEV_OFFSET_W-1:0] rsp_device_byte_offset;
   logic [SIZE_W-1:0]       rsp_column_bytes;
   logic                    rsp_last_column;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [LABEL_W-1:0]      csr_data = '0;
   int                      fail_count;
   int                      words_pending;
   bit                      steady = 1'b0;
   int unsigned             cfg_sh = 12;
   int unsigned             cfg_tc = 4;

   raidz_column_map i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_block_offset       (req_block_offset),
      .req_block_size         (req_block_size),
      .req_actual_bytes       (req_actual_bytes),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_column_number      (rsp_column_number),
      .rsp_device_index       (rsp_device_index),
      .rsp_device_byte_offset (rsp_device_byte_offset),
      .rsp_column_bytes       (rsp_column_bytes),
      .rsp_last_column        (rsp_last_column),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   raidz_column_map_checker i_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_block_offset       (req_block_offset),
      .req_block_size         (req_block_size),
      .req_actual_bytes       (req_actual_bytes),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_column_number      (rsp_column_number),
      .rsp_device_index       (rsp_device_index),
      .rsp_device_byte_offset (rsp_device_byte_offset),
      .rsp_column_bytes       (rsp_column_bytes),
      .rsp_last_column        (rsp_last_column),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .fail_count             (fail_count),
      .words_pending          (words_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 24);
   end

   task automatic send_request(input logic [OFFSET_W-1:0] offset,
                               input logic [SIZE_W-1:0]   bsize,
                               input logic [SIZE_W-1:0]   actual);
      if (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
      req_valid        <= 1'b1;
      req_block_offset <= offset;
      req_block_size   <= bsize;
      req_actual_bytes <= actual;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // wait for every predicted word, then let empty requests run out
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [LABEL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned sh, input int unsigned tc,
                               input int unsigned np, input logic [LABEL_W-1:0] label);
      drain();
      write_reg(CSR_SECTOR_SHIFT, LABEL_W'(sh));
      write_reg(CSR_TOTAL_COLUMNS, LABEL_W'(tc));
      write_reg(CSR_PARITY_COLUMNS, LABEL_W'(np));
      write_reg(CSR_LABEL_OFFSET, label);
      csr_valid <= 1'b0;
      cfg_sh = sh;
      cfg_tc = tc;
   endtask

   task automatic random_requests(input int count);
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   bsize;
      logic [SIZE_W-1:0]   actual;
      int unsigned         sectors;
      repeat (count) begin
         offset = OFFSET_W'({$urandom(), $urandom()});
         sectors = $urandom_range(1, 3 * cfg_tc + 2);
         case ($urandom_range(9))
            0:       bsize = SIZE_W'($urandom());
            1:       bsize = SIZE_W'(1) << (SIZE_W - 1);
            default: bsize = SIZE_W'(64'(sectors) << cfg_sh);
         endcase
         case ($urandom_range(3))
            0:       actual = SIZE_W'($urandom());
            1:       actual = bsize;
            default: actual = SIZE_W'($urandom_range(0, bsize));
         endcase
         send_request(offset, bsize, actual);
      end
   endtask

   initial begin
      int unsigned tc;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: 4 columns, single parity, 4 KiB sectors
      send_request(60'h0, 25'd12288, 25'd12288);
      send_request(60'h0, 25'd0, 25'd4096);
      send_request(60'h0, 25'd4095, 25'd4095);
      send_request(60'h10_0000, 25'd12288, 25'd12288);
      send_request(60'h10_1000, 25'd4096, 25'd4096);
      send_request(60'hFFF_FFFF_FFFF_FFFF, 25'd16777216, 25'd16777216);
      send_request(60'hFFF_FFFF_FFFF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF);
      send_request(60'h5000, 25'd24576, 25'd0);
      send_request(60'h2000, 25'd65536, 25'd5000);
      send_request(60'h555_5555_5555_5555, 25'd28672, 25'h155_5555);
      send_request(60'hAAA_AAAA_AAAA_AAAA, 25'd8192, 25'h0AA_AAAA);
      send_request(60'h0, 25'd16777216, 25'd0);
      send_request(60'h3000, 25'd36864, 25'd36864);
      send_request(60'hFFF, 25'd4097, 25'd1);
      send_request(60'h1F_F000, 25'd20480, 25'd9000);
      send_request(60'h30_0000, 25'd8192, 25'd8192);
      random_requests(15);

      steady = 1'b1;
      set_geometry(9, 16, 1, 32'h0);
      random_requests(15);
      steady = 1'b0;

      set_geometry(16, 2, 1, 32'hFFFF_FFFF);
      random_requests(15);
      set_geometry(9, 16, 3, $urandom());
      random_requests(15);
      set_geometry(0, 5, 2, $urandom());
      random_requests(10);
      set_geometry(13, 3, 2, $urandom());
      random_requests(10);

      // geometries the block must reject, and a shift that empties every block
      set_geometry(12, 1, 1, $urandom());
      random_requests(3);
      set_geometry(12, 17, 1, $urandom());
      random_requests(3);
      set_geometry(12, 31, 3, $urandom());
      random_requests(3);
      set_geometry(12, 0, 1, $urandom());
      random_requests(3);
      set_geometry(12, 4, 0, $urandom());
      random_requests(3);
      set_geometry(12, 3, 3, $urandom());
      random_requests(3);
      set_geometry(31, 8, 1, $urandom());
      random_requests(3);

      repeat (2) begin
         tc = $urandom_range(2, 16);
         set_geometry($urandom_range(9, 16), tc, $urandom_range(1, (tc > 3) ? 3 : tc - 1),
                      $urandom());
         random_requests(10);
      end

      drain();
      if (fail_count == 0 && words_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
